/* design/relay_node_failsafe_controller_core_assert.svh */
// ---------------------------------------------------------------------------
// Relay node failsafe controller - assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef RELAY_NODE_FAILSAFE_CONTROLLER_CORE_ASSERT_SVH
`define RELAY_NODE_FAILSAFE_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTH

// Checked outside reset.
`define RNFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define RNFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RNFC_ASSERT(lbl, clk, rst, prop, msg)
`define RNFC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/rnfc_pkg.sv */
// ---------------------------------------------------------------------------
// Relay node failsafe controller - shared package
// Node state encodings, codes, item and state structs, small decode helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rnfc_pkg;

  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  // Node state machine, one-hot.
  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_DISC = 6'b000010,
    ST_OPER = 6'b000100,
    ST_AUTO = 6'b001000,
    ST_MAN  = 6'b010000,
    ST_FAIL = 6'b100000
  } nstate_t;

  // Node state codes as reported on the result stream.
  localparam logic [2:0] NODE_INIT = 3'd0;
  localparam logic [2:0] NODE_DISC = 3'd1;
  localparam logic [2:0] NODE_OPER = 3'd2;
  localparam logic [2:0] NODE_AUTO = 3'd3;
  localparam logic [2:0] NODE_MAN  = 3'd4;
  localparam logic [2:0] NODE_FAIL = 3'd5;

  typedef enum logic [1:0] {
    SRC_AUTO = 2'd0,
    SRC_MAN  = 2'd1,
    SRC_FAIL = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_HEARTBEAT = 3'd1,
    ACT_RELAY_CMD = 3'd2,
    ACT_DISCOVER  = 3'd3,
    ACT_OPERATE   = 3'd4
  } action_t;

  localparam logic [1:0] PROF_FAN   = 2'd0;
  localparam logic [1:0] PROF_LIGHT = 2'd1;

  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_APPLIED  = 2'd1;
  localparam logic [1:0] CMD_REJECTED = 2'd2;

  localparam logic [3:0] RELAY_ALL_ON  = 4'hF;
  localparam logic [3:0] RELAY_ALL_OFF = 4'h0;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

  typedef struct packed {
    nstate_t          st;
    src_t             src;
    logic [3:0]       relay;   // bit0 swing, bit1 low, bit2 medium, bit3 high
    logic [CNT_W-1:0] cnt;     // ms since last heartbeat, saturating
  } node_t;

  typedef struct packed {
    action_t action;
    logic    sw_auto;
    logic    cmd_swing;
    logic    cmd_low;
    logic    cmd_med;
    logic    cmd_high;
  } item_t;

  function automatic logic [2:0] node_code(input nstate_t st);
    logic [2:0] code;
    case (st)
      ST_INIT: code = NODE_INIT;
      ST_DISC: code = NODE_DISC;
      ST_OPER: code = NODE_OPER;
      ST_AUTO: code = NODE_AUTO;
      ST_MAN:  code = NODE_MAN;
      ST_FAIL: code = NODE_FAIL;
      default: code = NODE_INIT;
    endcase
    return code;
  endfunction

  // Highest lit speed relay wins.
  function automatic logic [1:0] speed_level_of(input logic [3:0] relay);
    logic [1:0] speed;
    if (relay[3]) begin
      speed = 2'd3;
    end else if (relay[2]) begin
      speed = 2'd2;
    end else if (relay[1]) begin
      speed = 2'd1;
    end else begin
      speed = 2'd0;
    end
    return speed;
  endfunction

endpackage

/* design/relay_node_failsafe_controller_core.sv */
// ---------------------------------------------------------------------------
// Relay node failsafe controller - top level
// Four-relay fan node controller: node state, heartbeat watchdog, failsafe.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                 Contents
//  s_axis   in   s_axis_tvalid/tready      request: action, mode switch, relay cmd
//  m_axis   out  m_axis_tvalid/tready      result: state, source, relays, status
//  cfg      in   cfg_we (no wait)          node_profile (0), heartbeat_timeout_ms (1)
//
//  One request per cycle sustained while m_axis_tready stays high. A request is
//  captured in the input register, runs through the step rule and lands in
//  the result register together with the node state update once the result
//  register is free or being drained; its result is then valid on m_axis. With
//  m_axis_tready low the result register holds and the input register can
//  still take one more request. rst is synchronous: node in init, source
//  auto, relays off, heartbeat count zero, profile fan, timeout 10000.
//
`timescale 1ns / 1ps
`include "relay_node_failsafe_controller_core_assert.svh"

module relay_node_failsafe_controller_core (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] mode_switch_auto, [1] cmd_swing, [2] cmd_low,
                                      // [3] cmd_med, [4] cmd_high, [7:5] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] node_state, [4:3] drive_source,
                                      // [8:5] relay_bits, [10:9] speed_level,
                                      // [11] status_report, [13:12] command_status,
                                      // [15:14] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rnfc_pkg::*;

  localparam logic CFG_PROFILE = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // configuration
  logic [1:0]  profile;
  logic [15:0] timeout;

  // input register
  logic  in_vld;
  item_t in_item;

  // node state and result register
  node_t       node;
  node_t       node_next;
  logic        rule_report;
  logic [1:0]  rule_cmd_status;
  logic        out_vld;
  logic [15:0] out_data;

  logic fire;

  // The step runs when the result register is free or being drained.
  assign fire          = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || fire;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      profile <= PROF_FAN;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROFILE: profile <= cfg_data[1:0];
        CFG_TIMEOUT: timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.action    <= action_t'(s_axis_tuser);
      in_item.sw_auto   <= s_axis_tdata[0];
      in_item.cmd_swing <= s_axis_tdata[1];
      in_item.cmd_low   <= s_axis_tdata[2];
      in_item.cmd_med   <= s_axis_tdata[3];
      in_item.cmd_high  <= s_axis_tdata[4];
    end
  end

  rnfc_rule u_rule (
    .cur        (node),
    .item       (in_item),
    .profile    (profile),
    .timeout    (timeout),
    .nxt        (node_next),
    .report     (rule_report),
    .cmd_status (rule_cmd_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node.st    <= ST_INIT;
      node.src   <= SRC_AUTO;
      node.relay <= RELAY_ALL_OFF;
      node.cnt   <= '0;
    end else if (fire) begin
      node <= node_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  // Result reflects the node after the step.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {2'b00, rule_cmd_status, rule_report,
                   speed_level_of(node_next.relay), node_next.relay,
                   node_next.src, node_code(node_next.st)};
    end
  end

  // Failsafe node state always reports the failsafe source.
  `RNFC_ASSERT(a_fail_src, clk, rst, (m_axis_tvalid && m_axis_tdata[2:0] == NODE_FAIL) |-> (m_axis_tdata[4:3] == SRC_FAIL), "failsafe state without failsafe source")
  // A rejected relay command leaves the relays alone.
  `RNFC_ASSERT(a_reject_hold, clk, rst, (fire && rule_cmd_status == CMD_REJECTED) |=> (node.relay == $past(node.relay)), "rejected command changed relays")
  // A heartbeat clears the watchdog count.
  `RNFC_ASSERT(a_hb_clear, clk, rst, (fire && in_item.action == ACT_HEARTBEAT) |=> (node.cnt == '0), "heartbeat did not clear count")
  // Backpressure on the request side only when both registers are full and stalled.
  `RNFC_ASSERT(a_ready_stall, clk, rst, !s_axis_tready |-> (in_vld && out_vld && !m_axis_tready), "request side stalled without cause")

endmodule

/* design/rnfc_rule.sv */
// ---------------------------------------------------------------------------
// Relay node failsafe controller - step rule
// Next node state, report flag and command status for one request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnfc_rule (
  input  rnfc_pkg::node_t cur,
  input  rnfc_pkg::item_t item,
  input  logic [1:0]      profile,
  input  logic [15:0]     timeout,
  output rnfc_pkg::node_t nxt,
  output logic            report,
  output logic [1:0]      cmd_status
);
  import rnfc_pkg::*;

  logic [CNT_W-1:0] cnt_inc;
  logic             overdue;
  logic             recovered;
  logic [1:0]       speed_cnt;
  logic [3:0]       relay_cmd;
  logic [3:0]       relay_fail;
  logic             fan;

  assign cnt_inc    = (cur.cnt == COUNT_MAX) ? cur.cnt : cur.cnt + 1'b1;
  assign overdue    = cnt_inc > {1'b0, timeout};
  assign recovered  = cnt_inc < {1'b0, timeout};
  assign fan        = (profile == PROF_FAN);
  assign relay_fail = (profile == PROF_LIGHT) ? RELAY_ALL_ON : RELAY_ALL_OFF;
  assign speed_cnt  = {1'b0, item.cmd_low} + {1'b0, item.cmd_med} + {1'b0, item.cmd_high};

  // Single-speed command; swing only rides along with a lit speed.
  always_comb begin
    relay_cmd = 4'b0000;
    if (item.cmd_high) begin
      relay_cmd[3] = 1'b1;
    end else if (item.cmd_med) begin
      relay_cmd[2] = 1'b1;
    end else if (item.cmd_low) begin
      relay_cmd[1] = 1'b1;
    end
    relay_cmd[0] = item.cmd_swing && (relay_cmd[3:1] != 3'b000);
  end

  always_comb begin
    nxt        = cur;
    report     = 1'b0;
    cmd_status = CMD_NONE;
    case (item.action)
      ACT_TICK: begin
        nxt.cnt = cnt_inc;
        case (cur.st)
          ST_OPER: begin
            if (fan && !item.sw_auto) begin
              nxt.st  = ST_MAN;
              nxt.src = SRC_MAN;
            end else begin
              nxt.st  = ST_AUTO;
              nxt.src = SRC_AUTO;
            end
          end
          ST_AUTO, ST_MAN: begin
            if (overdue) begin
              nxt.st    = ST_FAIL;
              nxt.src   = SRC_FAIL;
              nxt.relay = relay_fail;
              report    = 1'b1;
            end else if (fan && cur.st == ST_AUTO && !item.sw_auto) begin
              nxt.st  = ST_MAN;
              nxt.src = SRC_MAN;
              report  = 1'b1;
            end else if (fan && cur.st == ST_MAN && item.sw_auto) begin
              nxt.st  = ST_AUTO;
              nxt.src = SRC_AUTO;
              report  = 1'b1;
            end
          end
          ST_FAIL: begin
            // source stays failsafe until the next tick in operational
            if (recovered) begin
              nxt.st = ST_OPER;
              report = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_HEARTBEAT: begin
        nxt.cnt = '0;
      end
      ACT_RELAY_CMD: begin
        if (speed_cnt > 2'd1) begin
          cmd_status = CMD_REJECTED;
        end else begin
          nxt.relay  = relay_cmd;
          cmd_status = CMD_APPLIED;
        end
      end
      ACT_DISCOVER: begin
        nxt.st = ST_DISC;
      end
      ACT_OPERATE: begin
        nxt.st = ST_OPER;
      end
      default: begin
      end
    endcase
  end

endmodule
